>>> rtl/core/fdr_pkg.sv
// Shared types and constants for the dielectric Fresnel reflectance pipeline.
`timescale 1ns / 1ps

package fdr_pkg;

    typedef struct packed {
        logic signed [15:0] cos_incident;
        logic [15:0]        rel_index;
    } in_word_t;

    typedef struct packed {
        logic [15:0] reflectance;
        logic        total_internal;
    } out_word_t;

    localparam int SQ_STEPS  = 30;
    localparam int DIV_STEPS = 30;

    localparam logic [15:0] UNITY_Q12 = 16'd4096;
    localparam logic [15:0] ONE_Q15   = 16'd32768;
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [30:0] ONE_Q28   = 31'h1000_0000;

endpackage

>>> rtl/core/fresnel_dielectric_reflectance_top.sv
// Throughput: one word per cycle; the pipe holds still only while the output
// register is full and not taken. The square root has 30 steps and the two
// restoring dividers 30 steps each, one result bit per stage.
// Reset: rst_n asynchronous active low clears all valid bits; no data reset.
`timescale 1ns / 1ps

module fresnel_dielectric_reflectance_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  fdr_pkg::in_word_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output fdr_pkg::out_word_t out_data
);
    import fdr_pkg::*;

    logic adv;
    assign adv      = !(out_valid && !out_ready);
    assign in_ready = adv;

    // stage 0: magnitude, orientation, squares
    logic        v0_reg;
    logic [15:0] c0_reg, d0_reg;
    logic [31:0] nn0_reg, dd0_reg;
    logic [31:0] cc0_reg;

    logic        in_inside;
    logic [15:0] in_c, in_n, in_d;
    always_comb
    begin
        in_inside = in_data.cos_incident[15];
        in_c = in_inside ? 16'(~in_data.cos_incident + 16'sd1) : 16'(in_data.cos_incident);
        in_n = in_inside ? UNITY_Q12 : in_data.rel_index;
        in_d = in_inside ? in_data.rel_index : UNITY_Q12;
    end

    // stage 1: sin^2 times D^2, and N^2 scaled
    logic        v1_reg;
    logic [15:0] c1_reg, d1_reg;
    logic [31:0] nn1_reg;
    logic [60:0] lhs1_reg;
    logic [28:0] s2;
    always_comb
    begin
        s2 = (cc0_reg >= 32'(ONE_Q28)) ? 29'd0 : 29'(32'(ONE_Q28) - cc0_reg);
    end

    // sqrt pipe, index 0 is the compare stage
    logic        sq_v_reg   [0:SQ_STEPS];
    logic        sq_tir_reg [0:SQ_STEPS];
    logic [15:0] sq_c_reg   [0:SQ_STEPS];
    logic [15:0] sq_d_reg   [0:SQ_STEPS];
    logic [31:0] sq_nn_reg  [0:SQ_STEPS];
    logic [60:0] sq_rem_reg [0:SQ_STEPS];
    logic [29:0] sq_rt_reg  [0:SQ_STEPS];

    logic [60:0] rhs1;
    assign rhs1 = {1'b0, nn1_reg, 28'd0};

    // products stage
    logic        v3_reg, tir3_reg;
    logic [47:0] a13_reg;
    logic [45:0] b13_reg;
    logic [31:0] a23_reg;
    logic [29:0] t3_reg;

    // divider pipe, index 0 is the numerator/denominator stage
    logic        dv_v_reg    [0:DIV_STEPS];
    logic        dv_tir_reg  [0:DIV_STEPS];
    logic        dv_one1_reg [0:DIV_STEPS];
    logic        dv_one2_reg [0:DIV_STEPS];
    logic [48:0] dv_den1_reg [0:DIV_STEPS];
    logic [48:0] dv_rem1_reg [0:DIV_STEPS];
    logic [32:0] dv_den2_reg [0:DIV_STEPS];
    logic [32:0] dv_rem2_reg [0:DIV_STEPS];
    logic [29:0] dv_q1_reg   [0:DIV_STEPS];
    logic [29:0] dv_q2_reg   [0:DIV_STEPS];

    logic [48:0] a1e, b1e, num1, den1;
    logic [32:0] a2e, b2e, num2, den2;
    always_comb
    begin
        a1e  = 49'(a13_reg);
        b1e  = 49'(b13_reg);
        num1 = (a1e >= b1e) ? a1e - b1e : b1e - a1e;
        den1 = a1e + b1e;
        a2e  = 33'(a23_reg);
        b2e  = 33'(t3_reg);
        num2 = (a2e >= b2e) ? a2e - b2e : b2e - a2e;
        den2 = a2e + b2e;
    end

    // squares stage
    logic        v5_reg, tir5_reg;
    logic [61:0] sq15_reg, sq25_reg;
    logic [30:0] r1, r2;
    always_comb
    begin
        r1 = dv_one1_reg[DIV_STEPS] ? ONE_Q30 : {1'b0, dv_q1_reg[DIV_STEPS]};
        r2 = dv_one2_reg[DIV_STEPS] ? ONE_Q30 : {1'b0, dv_q2_reg[DIV_STEPS]};
    end

    logic [62:0] sum5;
    logic [16:0] mean5;
    always_comb
    begin
        sum5  = 63'(sq15_reg) + 63'(sq25_reg);
        mean5 = sum5[62:46];
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            out_valid <= 1'b0;
            for (int i = 0; i <= SQ_STEPS; i++)
                sq_v_reg[i] <= 1'b0;
            for (int i = 0; i <= DIV_STEPS; i++)
                dv_v_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg      <= in_valid;
            v1_reg      <= v0_reg;
            sq_v_reg[0] <= v1_reg;
            for (int i = 0; i < SQ_STEPS; i++)
                sq_v_reg[i+1] <= sq_v_reg[i];
            v3_reg      <= sq_v_reg[SQ_STEPS];
            dv_v_reg[0] <= v3_reg;
            for (int i = 0; i < DIV_STEPS; i++)
                dv_v_reg[i+1] <= dv_v_reg[i];
            v5_reg      <= dv_v_reg[DIV_STEPS];
            out_valid   <= v5_reg;
        end
    end

    // fixed stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c0_reg  <= in_c;
            d0_reg  <= in_d;
            nn0_reg <= 32'(in_n) * 32'(in_n);
            dd0_reg <= 32'(in_d) * 32'(in_d);
            cc0_reg <= 32'(in_c) * 32'(in_c);

            c1_reg   <= c0_reg;
            d1_reg   <= d0_reg;
            nn1_reg  <= nn0_reg;
            lhs1_reg <= 61'(s2) * 61'(dd0_reg);

            sq_tir_reg[0] <= (lhs1_reg >= rhs1);
            sq_rem_reg[0] <= rhs1 - lhs1_reg;
            sq_rt_reg[0]  <= '0;
            sq_c_reg[0]   <= c1_reg;
            sq_d_reg[0]   <= d1_reg;
            sq_nn_reg[0]  <= nn1_reg;

            tir3_reg <= sq_tir_reg[SQ_STEPS];
            t3_reg   <= sq_rt_reg[SQ_STEPS];
            a13_reg  <= 48'(sq_nn_reg[SQ_STEPS]) * 48'(sq_c_reg[SQ_STEPS]);
            b13_reg  <= 46'(sq_rt_reg[SQ_STEPS]) * 46'(sq_d_reg[SQ_STEPS]);
            a23_reg  <= 32'(sq_c_reg[SQ_STEPS]) * 32'(sq_d_reg[SQ_STEPS]);

            dv_tir_reg[0]  <= tir3_reg;
            dv_one1_reg[0] <= (den1 == '0) || (num1 >= den1);
            dv_one2_reg[0] <= (den2 == '0) || (num2 >= den2);
            dv_den1_reg[0] <= den1;
            dv_rem1_reg[0] <= num1;
            dv_den2_reg[0] <= den2;
            dv_rem2_reg[0] <= num2;
            dv_q1_reg[0]   <= '0;
            dv_q2_reg[0]   <= '0;

            tir5_reg <= dv_tir_reg[DIV_STEPS];
            sq15_reg <= 62'(r1) * 62'(r1);
            sq25_reg <= 62'(r2) * 62'(r2);

            if (tir5_reg)
            begin
                out_data.reflectance    <= ONE_Q15;
                out_data.total_internal <= 1'b1;
            end
            else
            begin
                out_data.reflectance    <= (mean5 > 17'(ONE_Q15)) ? ONE_Q15 : mean5[15:0];
                out_data.total_internal <= 1'b0;
            end
        end
    end

    // square root: one result bit per stage, MSB first
    for (genvar j = 0; j < SQ_STEPS; j++)
    begin : g_sqrt
        localparam int K = SQ_STEPS - 1 - j;
        logic [61:0] trial;
        logic        take;
        always_comb
        begin
            trial = (62'(sq_rt_reg[j]) << (K + 1)) + (62'd1 << (2 * K));
            take  = 62'(sq_rem_reg[j]) >= trial;
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rem_reg[j+1] <= take ? 61'(62'(sq_rem_reg[j]) - trial) : sq_rem_reg[j];
                sq_rt_reg[j+1]  <= take ? (sq_rt_reg[j] | (30'd1 << K)) : sq_rt_reg[j];
                sq_tir_reg[j+1] <= sq_tir_reg[j];
                sq_c_reg[j+1]   <= sq_c_reg[j];
                sq_d_reg[j+1]   <= sq_d_reg[j];
                sq_nn_reg[j+1]  <= sq_nn_reg[j];
            end
        end
    end

    // restoring dividers, both ratios side by side
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic [49:0] sh1;
        logic [33:0] sh2;
        logic        ge1, ge2;
        always_comb
        begin
            sh1 = {dv_rem1_reg[j], 1'b0};
            sh2 = {dv_rem2_reg[j], 1'b0};
            ge1 = sh1 >= 50'(dv_den1_reg[j]);
            ge2 = sh2 >= 34'(dv_den2_reg[j]);
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem1_reg[j+1] <= 49'(ge1 ? sh1 - 50'(dv_den1_reg[j]) : sh1);
                dv_rem2_reg[j+1] <= 33'(ge2 ? sh2 - 34'(dv_den2_reg[j]) : sh2);
                dv_q1_reg[j+1]   <= {dv_q1_reg[j][28:0], ge1};
                dv_q2_reg[j+1]   <= {dv_q2_reg[j][28:0], ge2};
                dv_den1_reg[j+1] <= dv_den1_reg[j];
                dv_den2_reg[j+1] <= dv_den2_reg[j];
                dv_one1_reg[j+1] <= dv_one1_reg[j];
                dv_one2_reg[j+1] <= dv_one2_reg[j];
                dv_tir_reg[j+1]  <= dv_tir_reg[j];
            end
        end
    end

endmodule

>>> bench/fresnel_dielectric_reflectance_top_test.sv
// Self-checking bench for the dielectric Fresnel reflectance pipeline.
`timescale 1ns / 1ps

module fresnel_dielectric_reflectance_top_test;
    import fdr_pkg::*;

    localparam int LATENCY   = 67;
    localparam int WDOG_MAX  = 20000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_data;

    out_word_t expected_q[$];
    int        errors;
    int        idle_cycles;
    bit        hold_off;
    bit        stall_en;

    fresnel_dielectric_reflectance_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // floor(a/b) in Q30, saturating to one
    function automatic logic [63:0] frac_q30(logic [63:0] a, logic [63:0] b);
        logic [63:0] rem;
        logic [63:0] q;
        if (b == 0 || a >= b)
            return 64'd1 << 30;
        rem = a;
        q = 0;
        for (int i = 0; i < 30; i++)
        begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= b)
            begin
                rem = rem - b;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function automatic out_word_t fresnel_reflectance(in_word_t w);
        out_word_t   r;
        logic        ray_in;
        logic [63:0] c, n, d, s2, lhs, rhs, t, a1, b1, a2, r1, r2, sum, cc;
        ray_in = w.cos_incident[15];
        c  = ray_in ? 64'(17'h10000 - {1'b0, w.cos_incident}) : 64'(w.cos_incident[15:0]);
        n  = ray_in ? 64'd4096 : 64'(w.rel_index);
        d  = ray_in ? 64'(w.rel_index) : 64'd4096;
        cc = c * c;
        s2 = (cc >= (64'd1 << 28)) ? 64'd0 : (64'd1 << 28) - cc;
        lhs = s2 * (d * d);
        rhs = (n * n) << 28;
        if (lhs >= rhs)
        begin
            r.reflectance = ONE_Q15;
            r.total_internal = 1'b1;
            return r;
        end
        t  = int_sqrt(rhs - lhs);
        a1 = (n * n) * c;
        b1 = t * d;
        r1 = frac_q30(a1 >= b1 ? a1 - b1 : b1 - a1, a1 + b1);
        a2 = c * d;
        r2 = frac_q30(a2 >= t ? a2 - t : t - a2, a2 + t);
        sum = (r1 * r1 + r2 * r2) >> 46;
        if (sum > 64'(ONE_Q15))
            sum = 64'(ONE_Q15);
        r.reflectance = sum[15:0];
        r.total_internal = 1'b0;
        return r;
    endfunction

    function automatic int short_gap();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    // valid stays high after a word is taken only when the next word follows at once
    task automatic send_word(logic [15:0] cosv, logic [15:0] eta, bit gaps);
        int g;
        g = gaps ? short_gap() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_data.cos_incident <= cosv;
        in_data.rel_index    <= eta;
        in_valid             <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        expected_q.push_back(fresnel_reflectance({cosv, eta}));
    endtask

    task automatic drain();
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // receiver
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off)
            out_ready <= 1'b0;
        else if (stall_en)
            out_ready <= ($urandom_range(0, 9) < 7);
        else
            out_ready <= 1'b1;
    end

    // result check and watchdog
    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result word with no expectation: %h", out_data);
                    errors = errors + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (out_data.reflectance !== e.reflectance)
                    begin
                        $error("reflectance: expected %0d, actual %0d",
                               e.reflectance, out_data.reflectance);
                        errors = errors + 1;
                    end
                    if (out_data.total_internal !== e.total_internal)
                    begin
                        $error("total_internal: expected %0d, actual %0d",
                               e.total_internal, out_data.total_internal);
                        errors = errors + 1;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("[fresnel_dielectric_reflectance_top] ERROR");
            $finish;
        end
    end

    task automatic test_directed();
        logic [15:0] cosv [9];
        logic [15:0] eta [6];
        cosv = '{16'sd16384, -16'sd16384, 16'sd0, 16'h8000, 16'h7FFF,
                 16'sd11585, -16'sd11585, 16'sd1, -16'sd1};
        eta  = '{16'd1, 16'd4096, 16'd6144, 16'd65535, 16'd0, 16'd2731};
        // grazing, normal, out-of-range cosine, unit and zero index cases
        for (int i = 0; i < 9; i++)
            for (int j = 0; j < 3; j++)
                send_word(cosv[i], eta[(i + j * 2) % 6], 1'b0);
        in_valid <= 1'b0;
        drain();
    endtask

    task automatic test_random();
        logic [15:0] cosv, eta;
        stall_en = 1'b1;
        for (int i = 0; i < 1000; i++)
        begin
            case ($urandom_range(0, 4))
                0: cosv = 16'($urandom);
                1: cosv = 16'($signed($urandom_range(0, 32768)) - 16384);
                default: cosv = 16'($signed($urandom_range(0, 32768)) - 16384);
            endcase
            case ($urandom_range(0, 3))
                0: eta = 16'($urandom);
                default: eta = 16'($urandom_range(2048, 12288));
            endcase
            send_word(cosv, eta, 1'b1);
        end
        in_valid <= 1'b0;
        drain();
    endtask

    task automatic test_backpressure();
        stall_en = 1'b0;
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 150; i++)
                    send_word(16'($urandom), 16'($urandom), 1'b0);
                in_valid <= 1'b0;
            end
        join
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        errors = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        stall_en = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random();
        if (errors == 0)
            $display("[fresnel_dielectric_reflectance_top] OK");
        else
            $display("[fresnel_dielectric_reflectance_top] ERROR");
        $finish;
    end

endmodule
